FILE: sv/qvoc_pkg.sv
// Shared widths, types and result structs for the quad vertex order and
// coplanarity check. No dependencies; every other file refers to it by scope.
package qvoc_pkg;

    localparam int CW   = 16;          // coordinate width
    localparam int NPTS = 4;           // corners of a face
    localparam int DFW  = CW + 1;      // difference of two coordinates
    localparam int NRW  = 2 * CW;      // squared norm of a point
    localparam int DSW  = 2 * CW + 2;  // squared distance between two points
    localparam int DTW  = 2 * CW + 3;  // 2x2 determinant of differences
    localparam int PRW  = 3 * CW + 5;  // plane test products and their sum

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [DFW-1:0] t_diff;
    typedef logic signed [NRW-1:0] t_sq;
    typedef logic        [NRW-1:0] t_norm;
    typedef logic signed [DSW-1:0] t_dsq;
    typedef logic        [DSW-1:0] t_dist;
    typedef logic signed [DTW-1:0] t_det;
    typedef logic signed [PRW-1:0] t_prod;
    typedef logic        [1:0]     t_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef t_point [NPTS-1:0] t_quad;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    // Ordered face: source index per slot and slots 1..3 relative to slot 0
    typedef struct packed {
        t_idx [NPTS-1:0] slot;
        t_dvec           d1;
        t_dvec           d2;
        t_dvec           d3;
    } t_order;

    typedef struct packed {
        t_idx [NPTS-1:0] slot;
        logic            coplanar;
        logic            degenerate;
    } t_result;

endpackage

FILE: sv/qvoc_order.sv
// Four-stage ordering pipeline: norms, closest corner, distances, slot assignment.
// Depends on qvoc_pkg for point, difference and ordered-face types.
module qvoc_order (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qvoc_pkg::t_quad  i_quad,
    output logic             o_valid,
    input  logic             i_ready,
    output qvoc_pkg::t_order o_order
);

    localparam int NSTG = 4;

    function automatic qvoc_pkg::t_norm f_norm(input qvoc_pkg::t_point p);
        qvoc_pkg::t_sq sx;
        qvoc_pkg::t_sq sy;
        qvoc_pkg::t_sq sz;
        sx = qvoc_pkg::t_sq'(p.x) * qvoc_pkg::t_sq'(p.x);
        sy = qvoc_pkg::t_sq'(p.y) * qvoc_pkg::t_sq'(p.y);
        sz = qvoc_pkg::t_sq'(p.z) * qvoc_pkg::t_sq'(p.z);
        return qvoc_pkg::t_norm'(sx) + qvoc_pkg::t_norm'(sy) + qvoc_pkg::t_norm'(sz);
    endfunction

    function automatic qvoc_pkg::t_dist f_dist(input qvoc_pkg::t_dvec d);
        qvoc_pkg::t_dsq sx;
        qvoc_pkg::t_dsq sy;
        qvoc_pkg::t_dsq sz;
        sx = qvoc_pkg::t_dsq'(d.x) * qvoc_pkg::t_dsq'(d.x);
        sy = qvoc_pkg::t_dsq'(d.y) * qvoc_pkg::t_dsq'(d.y);
        sz = qvoc_pkg::t_dsq'(d.z) * qvoc_pkg::t_dsq'(d.z);
        return qvoc_pkg::t_dist'(sx) + qvoc_pkg::t_dist'(sy) + qvoc_pkg::t_dist'(sz);
    endfunction

    function automatic qvoc_pkg::t_dvec f_sub(input qvoc_pkg::t_point a,
                                              input qvoc_pkg::t_point b);
        qvoc_pkg::t_dvec d;
        d.x = qvoc_pkg::t_diff'(a.x) - qvoc_pkg::t_diff'(b.x);
        d.y = qvoc_pkg::t_diff'(a.y) - qvoc_pkg::t_diff'(b.y);
        d.z = qvoc_pkg::t_diff'(a.z) - qvoc_pkg::t_diff'(b.z);
        return d;
    endfunction

    // Stage valid bits and the ready chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_rdy;

    // Stage 1: points and their squared norms
    qvoc_pkg::t_quad r1_quad;
    qvoc_pkg::t_norm r1_norm [qvoc_pkg::NPTS];

    // Stage 2: closest corner in position 0, the rest relative to it
    qvoc_pkg::t_idx  r2_id [qvoc_pkg::NPTS];
    qvoc_pkg::t_dvec r2_d  [1:3];

    // Stage 3: adds squared distances from position 0
    qvoc_pkg::t_idx  r3_id   [qvoc_pkg::NPTS];
    qvoc_pkg::t_dvec r3_d    [1:3];
    qvoc_pkg::t_dist r3_dist [1:3];

    // Stage 4: final slot order
    qvoc_pkg::t_order r4_order;

    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld[0] = w_rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Closest corner: pairwise minimum tree, ties keep the lower index
    qvoc_pkg::t_idx  w_c01;
    qvoc_pkg::t_idx  w_c23;
    qvoc_pkg::t_idx  w_c;
    qvoc_pkg::t_norm w_m01;
    qvoc_pkg::t_norm w_m23;
    qvoc_pkg::t_point w_base;
    qvoc_pkg::t_idx  w2_id [qvoc_pkg::NPTS];
    qvoc_pkg::t_dvec w2_d  [1:3];

    always_comb begin
        w_c01 = (r1_norm[1] < r1_norm[0]) ? 2'd1 : 2'd0;
        w_m01 = (r1_norm[1] < r1_norm[0]) ? r1_norm[1] : r1_norm[0];
        w_c23 = (r1_norm[3] < r1_norm[2]) ? 2'd3 : 2'd2;
        w_m23 = (r1_norm[3] < r1_norm[2]) ? r1_norm[3] : r1_norm[2];
        w_c   = (w_m23 < w_m01) ? w_c23 : w_c01;
        w_base   = r1_quad[w_c];
        w2_id[0] = w_c;
        // The displaced corner 0 takes the closest corner's old position
        for (int k = 1; k < qvoc_pkg::NPTS; k++) begin
            if (w_c == qvoc_pkg::t_idx'(k)) begin
                w2_id[k] = 2'd0;
                w2_d[k]  = f_sub(r1_quad[0], w_base);
            end else begin
                w2_id[k] = qvoc_pkg::t_idx'(k);
                w2_d[k]  = f_sub(r1_quad[k], w_base);
            end
        end
    end

    // Farthest from slot 0 into slot 2, then larger x into slot 1
    logic            w_f2;
    logic            w_f3;
    qvoc_pkg::t_dist w_dmax;
    qvoc_pkg::t_idx  w_i1;
    qvoc_pkg::t_idx  w_i2;
    qvoc_pkg::t_idx  w_i3;
    qvoc_pkg::t_dvec w_v1;
    qvoc_pkg::t_dvec w_v2;
    qvoc_pkg::t_dvec w_v3;
    qvoc_pkg::t_order w4_order;

    always_comb begin
        w_f2   = r3_dist[1] < r3_dist[2];
        w_dmax = w_f2 ? r3_dist[2] : r3_dist[1];
        w_f3   = w_dmax < r3_dist[3];
        if (w_f3) begin
            w_i1 = r3_id[1]; w_v1 = r3_d[1];
            w_i2 = r3_id[3]; w_v2 = r3_d[3];
            w_i3 = r3_id[2]; w_v3 = r3_d[2];
        end else if (w_f2) begin
            w_i1 = r3_id[1]; w_v1 = r3_d[1];
            w_i2 = r3_id[2]; w_v2 = r3_d[2];
            w_i3 = r3_id[3]; w_v3 = r3_d[3];
        end else begin
            w_i1 = r3_id[2]; w_v1 = r3_d[2];
            w_i2 = r3_id[1]; w_v2 = r3_d[1];
            w_i3 = r3_id[3]; w_v3 = r3_d[3];
        end
        w4_order.slot[0] = r3_id[0];
        w4_order.slot[2] = w_i2;
        w4_order.d2      = w_v2;
        // Equal x leaves slots 1 and 3 as they are
        if (w_v1.x < w_v3.x) begin
            w4_order.slot[1] = w_i3; w4_order.d1 = w_v3;
            w4_order.slot[3] = w_i1; w4_order.d3 = w_v1;
        end else begin
            w4_order.slot[1] = w_i1; w4_order.d1 = w_v1;
            w4_order.slot[3] = w_i3; w4_order.d3 = w_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_quad <= i_quad;
            for (int k = 0; k < qvoc_pkg::NPTS; k++) begin
                r1_norm[k] <= f_norm(i_quad[k]);
            end
        end
        if (w_rdy[1]) begin
            r2_id <= w2_id;
            r2_d  <= w2_d;
        end
        if (w_rdy[2]) begin
            r3_id <= r2_id;
            r3_d  <= r2_d;
            for (int k = 1; k < qvoc_pkg::NPTS; k++) begin
                r3_dist[k] <= f_dist(r2_d[k]);
            end
        end
        if (w_rdy[3]) begin
            r4_order <= w4_order;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_order = r4_order;

endmodule

FILE: sv/qvoc_plane.sv
// Three-stage exact coplanarity test on the ordered face: determinants,
// cross products with z, then the final compare. Depends on qvoc_pkg.
module qvoc_plane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qvoc_pkg::t_order  i_order,
    output logic              o_valid,
    input  logic              i_ready,
    output qvoc_pkg::t_result o_result
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_rdy;

    // Stage 1: xy determinants
    qvoc_pkg::t_idx [qvoc_pkg::NPTS-1:0] r1_slot;
    qvoc_pkg::t_det  r1_det;
    qvoc_pkg::t_det  r1_n1;
    qvoc_pkg::t_det  r1_n2;
    qvoc_pkg::t_diff r1_z1;
    qvoc_pkg::t_diff r1_z2;
    qvoc_pkg::t_diff r1_z3;

    // Stage 2: products with z
    qvoc_pkg::t_idx [qvoc_pkg::NPTS-1:0] r2_slot;
    qvoc_pkg::t_prod r2_lhs;
    qvoc_pkg::t_prod r2_t1;
    qvoc_pkg::t_prod r2_t2;
    logic            r2_degen;

    // Stage 3: output register
    qvoc_pkg::t_result r3_res;

    qvoc_pkg::t_det w_det;
    qvoc_pkg::t_det w_n1;
    qvoc_pkg::t_det w_n2;

    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld[0] = w_rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        w_det = qvoc_pkg::t_det'(i_order.d1.x) * qvoc_pkg::t_det'(i_order.d2.y)
              - qvoc_pkg::t_det'(i_order.d2.x) * qvoc_pkg::t_det'(i_order.d1.y);
        w_n1  = qvoc_pkg::t_det'(i_order.d3.x) * qvoc_pkg::t_det'(i_order.d2.y)
              - qvoc_pkg::t_det'(i_order.d3.y) * qvoc_pkg::t_det'(i_order.d2.x);
        w_n2  = qvoc_pkg::t_det'(i_order.d3.y) * qvoc_pkg::t_det'(i_order.d1.x)
              - qvoc_pkg::t_det'(i_order.d3.x) * qvoc_pkg::t_det'(i_order.d1.y);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_slot <= i_order.slot;
            r1_det  <= w_det;
            r1_n1   <= w_n1;
            r1_n2   <= w_n2;
            r1_z1   <= i_order.d1.z;
            r1_z2   <= i_order.d2.z;
            r1_z3   <= i_order.d3.z;
        end
        if (w_rdy[1]) begin
            r2_slot  <= r1_slot;
            r2_lhs   <= qvoc_pkg::t_prod'(r1_z3) * qvoc_pkg::t_prod'(r1_det);
            r2_t1    <= qvoc_pkg::t_prod'(r1_z1) * qvoc_pkg::t_prod'(r1_n1);
            r2_t2    <= qvoc_pkg::t_prod'(r1_z2) * qvoc_pkg::t_prod'(r1_n2);
            r2_degen <= (r1_det == '0);
        end
        if (w_rdy[2]) begin
            r3_res.slot       <= r2_slot;
            r3_res.degenerate <= r2_degen;
            // A zero determinant never reports coplanar
            r3_res.coplanar   <= !r2_degen && (r2_lhs == r2_t1 + r2_t2);
        end
    end

    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[NSTG-1];
    assign o_result = r3_res;

endmodule

FILE: sv/quad_vertex_order_coplanar_check_top.sv
// Quad face vertex ordering and exact coplanarity check, top level.
// One input item carries four corners (x, y, z, signed 16 bits each) on
// i_valid / o_ready; one result item per input comes out on o_valid / i_ready:
// the source corner index for each of the four slots plus the coplanar and
// degenerate flags.
// Slot 0 holds the corner closest to the origin, slot 2 the one farthest from
// slot 0, slot 1 the larger x of the two left, slot 3 the other; ties keep the
// earlier corner. Degenerate means a zero xy determinant, and coplanar is then 0.
// Stages: four in the ordering pipeline, three in the plane test, the last
// being the output register. Throughput is one item per clock, set by the
// seven pipeline registers each taking a new item whenever the stage after
// it moves.
// When the receiver holds i_ready low the result stays on the outputs and
// the stages behind it fill; empty stages keep taking items, so o_ready
// drops only once all seven stages hold an item.
// Synchronous active-low reset clears all stage valid bits; nothing is in
// flight after reset. Depends on qvoc_pkg, qvoc_order and qvoc_plane.
module quad_vertex_order_coplanar_check_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qvoc_pkg::t_coord i_p1_x,
    input  qvoc_pkg::t_coord i_p1_y,
    input  qvoc_pkg::t_coord i_p1_z,
    input  qvoc_pkg::t_coord i_p2_x,
    input  qvoc_pkg::t_coord i_p2_y,
    input  qvoc_pkg::t_coord i_p2_z,
    input  qvoc_pkg::t_coord i_p3_x,
    input  qvoc_pkg::t_coord i_p3_y,
    input  qvoc_pkg::t_coord i_p3_z,
    input  qvoc_pkg::t_coord i_p4_x,
    input  qvoc_pkg::t_coord i_p4_y,
    input  qvoc_pkg::t_coord i_p4_z,
    output logic             o_valid,
    input  logic             i_ready,
    output qvoc_pkg::t_idx   o_slot0_src,
    output qvoc_pkg::t_idx   o_slot1_src,
    output qvoc_pkg::t_idx   o_slot2_src,
    output qvoc_pkg::t_idx   o_slot3_src,
    output logic             o_coplanar,
    output logic             o_degenerate
);

    qvoc_pkg::t_quad   w_quad;
    qvoc_pkg::t_order  w_order;
    qvoc_pkg::t_result w_result;
    logic              w_ord_valid;
    logic              w_ord_ready;

    always_comb begin
        w_quad[0].x = i_p1_x; w_quad[0].y = i_p1_y; w_quad[0].z = i_p1_z;
        w_quad[1].x = i_p2_x; w_quad[1].y = i_p2_y; w_quad[1].z = i_p2_z;
        w_quad[2].x = i_p3_x; w_quad[2].y = i_p3_y; w_quad[2].z = i_p3_z;
        w_quad[3].x = i_p4_x; w_quad[3].y = i_p4_y; w_quad[3].z = i_p4_z;
    end

    qvoc_order u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_quad  (w_quad),
        .o_valid (w_ord_valid),
        .i_ready (w_ord_ready),
        .o_order (w_order)
    );

    qvoc_plane u_plane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_ord_valid),
        .o_ready  (w_ord_ready),
        .i_order  (w_order),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_result)
    );

    assign o_slot0_src  = w_result.slot[0];
    assign o_slot1_src  = w_result.slot[1];
    assign o_slot2_src  = w_result.slot[2];
    assign o_slot3_src  = w_result.slot[3];
    assign o_coplanar   = w_result.coplanar;
    assign o_degenerate = w_result.degenerate;

`ifndef SYNTHESIS
    // Slots must be a permutation of the four corners
    a_slots_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slot0_src != o_slot1_src) && (o_slot0_src != o_slot2_src) &&
                    (o_slot0_src != o_slot3_src) && (o_slot1_src != o_slot2_src) &&
                    (o_slot1_src != o_slot3_src) && (o_slot2_src != o_slot3_src))
        else $error("slot sources are not a permutation");

    a_degen_not_coplanar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> !o_coplanar)
        else $error("degenerate face reported coplanar");

    // With the output register empty every stage can move, so input is open
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");
`endif

endmodule

FILE: bench/qvoc_face_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the quad vertex order / coplanarity block, predicts
// each result from the accepted face and compares it field by field.
// Depends on qvoc_pkg for the face and result types.
module qvoc_face_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  qvoc_pkg::t_quad     i_face,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  qvoc_pkg::t_idx      i_slot0_src,
    input  qvoc_pkg::t_idx      i_slot1_src,
    input  qvoc_pkg::t_idx      i_slot2_src,
    input  qvoc_pkg::t_idx      i_slot3_src,
    input  logic                i_coplanar,
    input  logic                i_degenerate,
    output int                  o_fail_cnt,
    output int                  o_pending
);

    qvoc_pkg::t_result order_q[$];
    qvoc_pkg::t_result want;
    qvoc_pkg::t_idx    got_slot [qvoc_pkg::NPTS];

    // Order the corners and run the exact plane test on one face.
    function automatic qvoc_pkg::t_result order_face(qvoc_pkg::t_quad q);
        longint  px [qvoc_pkg::NPTS];
        longint  py [qvoc_pkg::NPTS];
        longint  pz [qvoc_pkg::NPTS];
        longint  nrm [qvoc_pkg::NPTS];
        longint  dx [qvoc_pkg::NPTS];
        longint  dy [qvoc_pkg::NPTS];
        longint  dz [qvoc_pkg::NPTS];
        longint  d_f, d_i;
        longint  det, n1, n2, lhs, rhs;
        int      ord [qvoc_pkg::NPTS];
        int      c, f, tmp;
        qvoc_pkg::t_result r;
        for (int i = 0; i < qvoc_pkg::NPTS; i++) begin
            px[i]  = longint'(q[i].x);
            py[i]  = longint'(q[i].y);
            pz[i]  = longint'(q[i].z);
            nrm[i] = px[i] * px[i] + py[i] * py[i] + pz[i] * pz[i];
            ord[i] = i;
        end
        // closest to origin, first seen wins a tie
        c = 0;
        for (int i = 1; i < qvoc_pkg::NPTS; i++)
            if (nrm[ord[i]] < nrm[ord[c]])
                c = i;
        tmp = ord[0]; ord[0] = ord[c]; ord[c] = tmp;
        // farthest from slot 0 among the rest
        f = 1;
        for (int i = 2; i < qvoc_pkg::NPTS; i++) begin
            d_f = (px[ord[f]] - px[ord[0]]) ** 2 + (py[ord[f]] - py[ord[0]]) ** 2
                + (pz[ord[f]] - pz[ord[0]]) ** 2;
            d_i = (px[ord[i]] - px[ord[0]]) ** 2 + (py[ord[i]] - py[ord[0]]) ** 2
                + (pz[ord[i]] - pz[ord[0]]) ** 2;
            if (d_f < d_i)
                f = i;
        end
        tmp = ord[2]; ord[2] = ord[f]; ord[f] = tmp;
        if (px[ord[1]] < px[ord[3]]) begin
            tmp = ord[1]; ord[1] = ord[3]; ord[3] = tmp;
        end
        for (int k = 1; k < qvoc_pkg::NPTS; k++) begin
            dx[k] = px[ord[k]] - px[ord[0]];
            dy[k] = py[ord[k]] - py[ord[0]];
            dz[k] = pz[ord[k]] - pz[ord[0]];
        end
        det = dx[1] * dy[2] - dx[2] * dy[1];
        n1  = dx[3] * dy[2] - dy[3] * dx[2];
        n2  = dy[3] * dx[1] - dx[3] * dy[1];
        lhs = dz[3] * det;
        rhs = dz[1] * n1 + dz[2] * n2;
        for (int k = 0; k < qvoc_pkg::NPTS; k++)
            r.slot[k] = qvoc_pkg::t_idx'(ord[k]);
        r.degenerate = (det == 0);
        r.coplanar   = (det != 0) && (lhs == rhs);
        return r;
    endfunction

    task automatic check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, expv, actv);
            o_fail_cnt++;
        end
    endtask

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                order_q.push_back(order_face(i_face));
            if (i_out_valid && i_out_ready) begin
                if (order_q.size() == 0) begin
                    $display({"%0t ns: unexpected result, expected none, ",
                              "got %0d %0d %0d %0d cp=%0b dg=%0b"},
                             $time, i_slot0_src, i_slot1_src, i_slot2_src, i_slot3_src,
                             i_coplanar, i_degenerate);
                    o_fail_cnt++;
                end else begin
                    want        = order_q.pop_front();
                    got_slot[0] = i_slot0_src;
                    got_slot[1] = i_slot1_src;
                    got_slot[2] = i_slot2_src;
                    got_slot[3] = i_slot3_src;
                    for (int k = 0; k < qvoc_pkg::NPTS; k++)
                        check_field($sformatf("slot%0d_src", k), want.slot[k], got_slot[k]);
                    check_field("coplanar", want.coplanar, i_coplanar);
                    check_field("degenerate", want.degenerate, i_degenerate);
                end
            end
            o_pending = order_q.size();
        end
    end

endmodule

FILE: bench/quad_vertex_order_coplanar_check_top_tb.sv
`timescale 1ns / 100ps
// Top of the bench: clock, reset, face stimulus and result back-pressure for
// quad_vertex_order_coplanar_check_top. Depends on qvoc_pkg and qvoc_face_checker.
module quad_vertex_order_coplanar_check_top_tb;

    localparam int N_RANDOM   = 1200;
    localparam int DRAIN_CYC  = 20;
    localparam int CYCLE_LIMIT = 400000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    logic            o_valid;
    logic            i_ready = 1'b0;
    qvoc_pkg::t_quad face = '0;
    qvoc_pkg::t_idx  o_slot0_src, o_slot1_src, o_slot2_src, o_slot3_src;
    logic            o_coplanar, o_degenerate;
    int              fail_cnt;
    int              pending;
    int unsigned     cycle_cnt = 0;
    int              send_calm = 0;
    int              recv_calm = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        cycle_cnt <= cycle_cnt + 1;

    quad_vertex_order_coplanar_check_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_p1_x       (face[0].x),
        .i_p1_y       (face[0].y),
        .i_p1_z       (face[0].z),
        .i_p2_x       (face[1].x),
        .i_p2_y       (face[1].y),
        .i_p2_z       (face[1].z),
        .i_p3_x       (face[2].x),
        .i_p3_y       (face[2].y),
        .i_p3_z       (face[2].z),
        .i_p4_x       (face[3].x),
        .i_p4_y       (face[3].y),
        .i_p4_z       (face[3].z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot0_src  (o_slot0_src),
        .o_slot1_src  (o_slot1_src),
        .o_slot2_src  (o_slot2_src),
        .o_slot3_src  (o_slot3_src),
        .o_coplanar   (o_coplanar),
        .o_degenerate (o_degenerate)
    );

    qvoc_face_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_face       (face),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_slot0_src  (o_slot0_src),
        .i_slot1_src  (o_slot1_src),
        .i_slot2_src  (o_slot2_src),
        .i_slot3_src  (o_slot3_src),
        .i_coplanar   (o_coplanar),
        .i_degenerate (o_degenerate),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending)
    );

    // Random pause per item, with occasional stretches of back-to-back items.
    function automatic int pick_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Present one face at the falling edge and hold it until accepted.
    task automatic drive_face(qvoc_pkg::t_quad q);
        int gap;
        gap = pick_pause(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        face    <= q;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drive_coords(int ax, int ay, int az, int bx, int by, int bz,
                                int cx, int cy, int cz, int dx, int dy, int dz);
        qvoc_pkg::t_quad q;
        q[0] = '{qvoc_pkg::t_coord'(ax), qvoc_pkg::t_coord'(ay), qvoc_pkg::t_coord'(az)};
        q[1] = '{qvoc_pkg::t_coord'(bx), qvoc_pkg::t_coord'(by), qvoc_pkg::t_coord'(bz)};
        q[2] = '{qvoc_pkg::t_coord'(cx), qvoc_pkg::t_coord'(cy), qvoc_pkg::t_coord'(cz)};
        q[3] = '{qvoc_pkg::t_coord'(dx), qvoc_pkg::t_coord'(dy), qvoc_pkg::t_coord'(dz)};
        drive_face(q);
    endtask

    function automatic qvoc_pkg::t_coord pick_edge();
        case ($urandom_range(0, 6))
            0: return qvoc_pkg::t_coord'(-32768);
            1: return qvoc_pkg::t_coord'(-32767);
            2: return qvoc_pkg::t_coord'(-1);
            3: return qvoc_pkg::t_coord'(0);
            4: return qvoc_pkg::t_coord'(1);
            5: return qvoc_pkg::t_coord'(32766);
            default: return qvoc_pkg::t_coord'(32767);
        endcase
    endfunction

    function automatic qvoc_pkg::t_quad random_face();
        qvoc_pkg::t_quad q;
        int    kind, a, b, c, x0, y0, ux, uy, t;
        kind = $urandom_range(0, 99);
        a  = srand(3);
        b  = srand(3);
        c  = srand(1000);
        x0 = srand(1000);
        y0 = srand(1000);
        ux = srand(50);
        uy = srand(50);
        for (int i = 0; i < qvoc_pkg::NPTS; i++) begin
            if (kind < 30) begin
                q[i].x = qvoc_pkg::t_coord'($urandom);
                q[i].y = qvoc_pkg::t_coord'($urandom);
                q[i].z = qvoc_pkg::t_coord'($urandom);
            end else if (kind < 60) begin
                // corners on a plane z = a*x + b*y + c
                q[i].x = qvoc_pkg::t_coord'(srand(4000));
                q[i].y = qvoc_pkg::t_coord'(srand(4000));
                q[i].z = qvoc_pkg::t_coord'(a * int'(q[i].x) + b * int'(q[i].y) + c);
            end else if (kind < 75) begin
                // tight cluster to provoke distance ties and flat faces
                q[i].x = qvoc_pkg::t_coord'(srand(3));
                q[i].y = qvoc_pkg::t_coord'(srand(3));
                q[i].z = qvoc_pkg::t_coord'(srand(3));
            end else if (kind < 85) begin
                q[i].x = pick_edge();
                q[i].y = pick_edge();
                q[i].z = pick_edge();
            end else begin
                // collinear in xy, free z
                t = srand(20);
                q[i].x = qvoc_pkg::t_coord'(x0 + t * ux);
                q[i].y = qvoc_pkg::t_coord'(y0 + t * uy);
                q[i].z = qvoc_pkg::t_coord'($urandom);
            end
        end
        return q;
    endfunction

    // Result side: hold ready low for a random pause, then wait for an item.
    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = pick_pause(recv_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed faces
        drive_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_coords(32767, 32767, 32767, 32767, 32767, 32767,
                     32767, 32767, 32767, 32767, 32767, 32767);
        drive_coords(-32768, -32768, -32768, -32768, -32768, -32768,
                     -32768, -32768, -32768, -32768, -32768, -32768);
        drive_coords(-32768, -32768, -32768, 32767, 32767, 32767,
                     32767, -32768, 0, -32768, 32767, 32767);
        drive_coords(0, 0, 0, 10, 0, 0, 10, 10, 0, 0, 10, 0);
        drive_coords(1, 1, 6, 5, 2, 12, 3, 7, 20, 8, 4, 19);
        drive_coords(1, 1, 6, 5, 2, 12, 3, 7, 20, 8, 4, 20);
        // every corner equally far from the origin
        drive_coords(1, 0, 0, 0, 1, 0, 0, 0, 1, -1, 0, 0);
        // equal x for the two side corners
        drive_coords(0, 0, 0, 5, 1, 0, 9, 9, 0, 5, 7, 2);
        // collinear in xy
        drive_coords(0, 0, 0, 1, 1, 5, 2, 2, -3, 3, 3, 7);
        drive_coords(3, 3, 3, 3, 3, 3, 3, 3, 3, 4, 3, 3);
        drive_coords(100, 100, 100, 50, 60, 70, -80, 90, 10, 1, 1, 1);
        drive_coords(-32768, -32768, 0, 32767, -32768, 0, 32767, 32767, 0, -32768, 32767, 0);
        drive_coords(-32768, -32768, -32768, 32767, -32768, -32768,
                     32767, 32767, -32768, -32768, 32767, -32768);
        drive_coords(-32768, -32768, 32767, 32767, -32768, 32767,
                     32767, 32767, 32767, -32768, 32767, 32767);
        drive_coords(32767, -32768, 32767, -32768, 32767, -32768,
                     32767, 32767, -32768, -32768, -32768, 32767);
        // farthest tie
        drive_coords(0, 0, 0, 3, 4, 0, 4, 3, 0, 0, 5, 0);
        // side corners arrive in the wrong x order
        drive_coords(0, 0, 0, -5, 1, 0, 9, 9, 0, 7, -2, 0);

        for (int n = 0; n < N_RANDOM; n++)
            drive_face(random_face());
        i_valid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: quad_vertex_order_coplanar_check_top.f
sv/qvoc_pkg.sv
sv/qvoc_order.sv
sv/qvoc_plane.sv
sv/quad_vertex_order_coplanar_check_top.sv
bench/qvoc_face_checker.sv
bench/quad_vertex_order_coplanar_check_top_tb.sv
